// ===== design/irrigation_pump_controller_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the irrigation pump controller core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IRRIGATION_PUMP_CONTROLLER_CORE_MACROS_SVH
`define IRRIGATION_PUMP_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irrigation pump controller: assertion failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irrigation pump controller: assertion failed");
`else
`define IPC_ASSERT_IMP(label, ante, cons)
`define IPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump controller package
// Field widths, register codes, watering modes and reset values.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // Schedule slots and their packing
    localparam int SCHEDULE_SLOTS = 4;
    localparam int SLOT_HOUR_W    = 5;
    localparam int SLOT_MIN_W     = 6;
    localparam int HOURS_REG_W    = 20;
    localparam int MINUTES_REG_W  = 24;
    localparam int HOURS_PAD_W    = (SLOT_HOUR_W * SCHEDULE_SLOTS > HOURS_REG_W) ?
                                    SLOT_HOUR_W * SCHEDULE_SLOTS : HOURS_REG_W;
    localparam int MINUTES_PAD_W  = (SLOT_MIN_W * SCHEDULE_SLOTS > MINUTES_REG_W) ?
                                    SLOT_MIN_W * SCHEDULE_SLOTS : MINUTES_REG_W;

    // Field widths
    localparam int MODE_W      = 3;
    localparam int PERCENT_W   = 7;
    localparam int TEMP_W      = 8;
    localparam int TLIMIT_W    = 6;
    localparam int RUN_W       = 12;
    localparam int COUNT_W     = 13;
    localparam int HOUR_W      = 5;
    localparam int MINSEC_W    = 6;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // Watering modes
    typedef enum logic [MODE_W-1:0] {
        MODE_MANUAL = 3'h1,
        MODE_HUMID  = 3'h2,
        MODE_SCHED  = 3'h3,
        MODE_MIXED  = 3'h4
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WATERING_MODE    = 4'd0,
        REG_STOP_BY_HUMIDITY = 4'd1,
        REG_HUMIDITY_LOW     = 4'd2,
        REG_HUMIDITY_HIGH    = 4'd3,
        REG_TEMP_LIMIT       = 4'd4,
        REG_RUN_SECONDS      = 4'd5,
        REG_SLOT_HOURS       = 4'd6,
        REG_SLOT_MINUTES     = 4'd7
    } cfg_index_t;

    // Reset values
    localparam logic [MODE_W-1:0]    RST_WATERING_MODE = 3'd1;
    localparam logic [PERCENT_W-1:0] RST_HUMIDITY_LOW  = 7'd35;
    localparam logic [PERCENT_W-1:0] RST_HUMIDITY_HIGH = 7'd65;
    localparam logic [TLIMIT_W-1:0]  RST_TEMP_LIMIT    = 6'd31;
    localparam logic [RUN_W-1:0]     RST_RUN_SECONDS   = 12'd10;
    localparam logic [MINSEC_W-1:0]  SECOND_IDLE       = 6'd50;

endpackage

// ===== design/irrigation_pump_controller_core.sv =====
// ----------------------------------------------------------------------------
// Irrigation pump controller core
// Sample-driven pump start/stop decision with countdown and schedule slots.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the input channel (in_valid/in_ready) carries one sample
//   of the clock time, humidity, temperature and the two key events. Each
//   sample gives exactly one result transfer on the output channel
//   (out_valid/out_ready): pump level, start and stop flags, and countdown.
//   A sample is captured in an input register and its result is computed from
//   it into the result register, which offers the result on the output
//   channel. One sample can be taken every cycle while results are accepted;
//   the single pass of compare and countdown logic between the two registers
//   sets that figure. While the receiver stalls, the result register holds
//   and the input register fills; in_ready then drops until the result moves.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no
//   sample is in flight; writing the run time while the pump is off reloads
//   the countdown. Reset (rst_n, asynchronous) empties both registers, turns
//   the pump off and restores all configuration defaults.
// ----------------------------------------------------------------------------
`include "irrigation_pump_controller_core_macros.svh"

module irrigation_pump_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Sample channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ipc_pkg::HOUR_W-1:0]           clock_hour,
    input  logic [ipc_pkg::MINSEC_W-1:0]         clock_minute,
    input  logic [ipc_pkg::MINSEC_W-1:0]         clock_second,
    input  logic [ipc_pkg::PERCENT_W-1:0]        humidity,
    input  logic signed [ipc_pkg::TEMP_W-1:0]    temperature,
    input  logic                                 manual_start,
    input  logic                                 stop_key,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pump_on,
    output logic                                 started,
    output logic                                 stopped,
    output logic signed [ipc_pkg::COUNT_W-1:0]   seconds_left
);

    // Configuration registers
    logic [ipc_pkg::MODE_W-1:0]        watering_mode_reg;
    logic                              stop_by_humidity_reg;
    logic [ipc_pkg::PERCENT_W-1:0]     humidity_low_reg;
    logic [ipc_pkg::PERCENT_W-1:0]     humidity_high_reg;
    logic [ipc_pkg::TLIMIT_W-1:0]      temp_limit_reg;
    logic [ipc_pkg::RUN_W-1:0]         run_seconds_reg;
    logic [ipc_pkg::HOURS_REG_W-1:0]   slot_hours_reg;
    logic [ipc_pkg::MINUTES_REG_W-1:0] slot_minutes_reg;

    // Controller state
    logic                              pump_running_reg, pump_running_next;
    logic signed [ipc_pkg::COUNT_W-1:0] countdown_reg, countdown_next;
    logic [ipc_pkg::MINSEC_W-1:0]      last_second_reg, last_second_next;

    // Input register
    logic                              in_valid_reg;
    logic [ipc_pkg::HOUR_W-1:0]        hour_reg;
    logic [ipc_pkg::MINSEC_W-1:0]      minute_reg;
    logic [ipc_pkg::MINSEC_W-1:0]      second_reg;
    logic [ipc_pkg::PERCENT_W-1:0]     humidity_reg;
    logic [ipc_pkg::TEMP_W-1:0]        temperature_reg;
    logic                              manual_reg;
    logic                              stop_key_reg;

    // Result register
    logic                              out_valid_reg;
    logic                              pump_on_reg;
    logic                              started_reg, started_next;
    logic                              stopped_reg, stopped_next;
    logic signed [ipc_pkg::COUNT_W-1:0] seconds_left_reg;

    // Handshake and pipeline advance
    logic result_free;
    logic advance;
    logic in_take;

    assign result_free = !out_valid_reg || out_ready;
    assign advance     = in_valid_reg && result_free;
    assign in_ready    = !in_valid_reg || result_free;
    assign in_take     = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign pump_on      = pump_on_reg;
    assign started      = started_reg;
    assign stopped      = stopped_reg;
    assign seconds_left = seconds_left_reg;

    // Schedule slot match against the registered sample
    logic [ipc_pkg::HOURS_PAD_W-1:0]   hours_pad;
    logic [ipc_pkg::MINUTES_PAD_W-1:0] minutes_pad;
    logic                              slot_match;

    assign hours_pad   = ipc_pkg::HOURS_PAD_W'(slot_hours_reg);
    assign minutes_pad = ipc_pkg::MINUTES_PAD_W'(slot_minutes_reg);

    always_comb
    begin
        slot_match = 1'b0;
        for (int i = 0; i < ipc_pkg::SCHEDULE_SLOTS; i++)
        begin
            if ((hours_pad[i*ipc_pkg::SLOT_HOUR_W +: ipc_pkg::SLOT_HOUR_W] != '0) &&
                (hours_pad[i*ipc_pkg::SLOT_HOUR_W +: ipc_pkg::SLOT_HOUR_W] == hour_reg) &&
                (minutes_pad[i*ipc_pkg::SLOT_MIN_W +: ipc_pkg::SLOT_MIN_W] == minute_reg))
            begin
                slot_match = 1'b1;
            end
        end
    end

    // Start conditions
    logic                                cool;
    logic                                sched_go;
    logic                                moist_go;
    logic                                auto_go;
    logic                                manual_go;
    logic signed [ipc_pkg::COUNT_W-1:0]  reload_value;

    assign cool = $signed({temperature_reg[ipc_pkg::TEMP_W-1], temperature_reg}) <
                  $signed({3'b000, temp_limit_reg});
    assign sched_go  = slot_match && (second_reg == '0) && cool &&
                       (humidity_reg < humidity_high_reg);
    assign moist_go  = (humidity_reg < humidity_low_reg) && cool;
    assign manual_go = !pump_running_reg && manual_reg &&
                       (watering_mode_reg == ipc_pkg::MODE_MANUAL);
    assign reload_value = $signed({1'b0, run_seconds_reg});

    always_comb
    begin
        unique case (watering_mode_reg)
            ipc_pkg::MODE_SCHED: auto_go = sched_go;
            ipc_pkg::MODE_HUMID: auto_go = moist_go;
            ipc_pkg::MODE_MIXED: auto_go = sched_go || moist_go;
            default:             auto_go = 1'b0;
        endcase
    end

    // One step of the controller for the registered sample
    always_comb
    begin
        logic                               running;
        logic signed [ipc_pkg::COUNT_W-1:0] count;

        running          = pump_running_reg || manual_go;
        count            = manual_go ? reload_value : countdown_reg;
        last_second_next = last_second_reg;
        started_next     = manual_go;
        stopped_next     = 1'b0;

        if (!running)
        begin
            if (auto_go)
            begin
                running      = 1'b1;
                started_next = 1'b1;
            end
        end
        else
        begin
            if (!stop_by_humidity_reg)
            begin
                if (second_reg != last_second_reg)
                begin
                    last_second_next = second_reg;
                    count            = count - ipc_pkg::COUNT_W'(1);
                end
                if (count < 0)
                begin
                    running          = 1'b0;
                    stopped_next     = 1'b1;
                    count            = reload_value;
                    last_second_next = ipc_pkg::SECOND_IDLE;
                end
            end
            else if (humidity_reg > humidity_high_reg)
            begin
                running      = 1'b0;
                stopped_next = 1'b1;
            end
            // The stop key acts last and, in this running branch, always reloads the countdown.
            if (stop_key_reg)
            begin
                if (running)
                begin
                    stopped_next = 1'b1;
                end
                running = 1'b0;
                count   = reload_value;
            end
        end

        pump_running_next = running;
        countdown_next    = count;
    end

    // Configuration, controller state and pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watering_mode_reg    <= ipc_pkg::RST_WATERING_MODE;
            stop_by_humidity_reg <= 1'b0;
            humidity_low_reg     <= ipc_pkg::RST_HUMIDITY_LOW;
            humidity_high_reg    <= ipc_pkg::RST_HUMIDITY_HIGH;
            temp_limit_reg       <= ipc_pkg::RST_TEMP_LIMIT;
            run_seconds_reg      <= ipc_pkg::RST_RUN_SECONDS;
            slot_hours_reg       <= '0;
            slot_minutes_reg     <= '0;
            pump_running_reg     <= 1'b0;
            countdown_reg        <= $signed({1'b0, ipc_pkg::RST_RUN_SECONDS});
            last_second_reg      <= ipc_pkg::SECOND_IDLE;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ipc_pkg::REG_WATERING_MODE:
                        watering_mode_reg <= cfg_data[ipc_pkg::MODE_W-1:0];
                    ipc_pkg::REG_STOP_BY_HUMIDITY:
                        stop_by_humidity_reg <= cfg_data[0];
                    ipc_pkg::REG_HUMIDITY_LOW:
                        humidity_low_reg <= cfg_data[ipc_pkg::PERCENT_W-1:0];
                    ipc_pkg::REG_HUMIDITY_HIGH:
                        humidity_high_reg <= cfg_data[ipc_pkg::PERCENT_W-1:0];
                    ipc_pkg::REG_TEMP_LIMIT:
                        temp_limit_reg <= cfg_data[ipc_pkg::TLIMIT_W-1:0];
                    ipc_pkg::REG_RUN_SECONDS:
                    begin
                        run_seconds_reg <= cfg_data[ipc_pkg::RUN_W-1:0];
                        if (!pump_running_reg)
                        begin
                            countdown_reg <= $signed({1'b0, cfg_data[ipc_pkg::RUN_W-1:0]});
                        end
                    end
                    ipc_pkg::REG_SLOT_HOURS:
                        slot_hours_reg <= cfg_data[ipc_pkg::HOURS_REG_W-1:0];
                    ipc_pkg::REG_SLOT_MINUTES:
                        slot_minutes_reg <= cfg_data[ipc_pkg::MINUTES_REG_W-1:0];
                    default:
                        ;
                endcase
            end
            else if (advance)
            begin
                pump_running_reg <= pump_running_next;
                countdown_reg    <= countdown_next;
                last_second_reg  <= last_second_next;
            end

            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (result_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Sample and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hour_reg        <= clock_hour;
            minute_reg      <= clock_minute;
            second_reg      <= clock_second;
            humidity_reg    <= humidity;
            temperature_reg <= temperature;
            manual_reg      <= manual_start;
            stop_key_reg    <= stop_key;
        end
        if (advance)
        begin
            pump_on_reg      <= pump_running_next;
            started_reg      <= started_next;
            stopped_reg      <= stopped_next;
            seconds_left_reg <= countdown_next;
        end
    end

    // Checks on the controller logic
    `IPC_ASSERT_IMP(a_start_stop_off, out_valid_reg && started_reg && stopped_reg, !pump_on_reg)
    `IPC_ASSERT_IMP(a_result_matches_state, out_valid_reg, pump_on_reg == pump_running_reg)
    `IPC_ASSERT_IMP(a_countdown_not_negative, 1'b1, !countdown_reg[ipc_pkg::COUNT_W-1])
    `IPC_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready, out_valid_reg && $stable(seconds_left_reg))

endmodule
